// File: src/touch_short_long_tap_detector_macros.svh
// ---------------------------------------------------------------------------
// Touch tap detector assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TOUCH_SHORT_LONG_TAP_DETECTOR_MACROS_SVH
`define TOUCH_SHORT_LONG_TAP_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define TSLTD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSLTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TSLTD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TSLTD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/tsltd_pkg.sv
// ---------------------------------------------------------------------------
// Touch tap detector package
// Shared types, register indexes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package tsltd_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LONG_W     = 16;
    localparam int DEB_W      = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEB_TICKS   = 2'd2;

    // Register reset values
    localparam logic              RST_ACTIVE_LOW = 1'b1;
    localparam logic [LONG_W-1:0] RST_LONG_TICKS = 16'd1000;
    localparam logic [DEB_W-1:0]  RST_DEB_TICKS  = 8'd20;

    typedef enum logic [1:0] {
        TAP_NONE  = 2'd0,
        TAP_SHORT = 2'd1,
        TAP_LONG  = 2'd2
    } t_tap_event;

    typedef struct packed {
        logic              active_low;
        logic [LONG_W-1:0] long_ticks;
        logic [DEB_W-1:0]  deb_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// File: src/tsltd_step.sv
// ---------------------------------------------------------------------------
// Touch tap detector step
// Debounce and press-timer state, updated once per accepted tick.
// ---------------------------------------------------------------------------
`default_nettype none

module tsltd_step
    import tsltd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_pin_level,
    input  wire t_cfg       i_cfg,
    output t_tap_event      o_tap_event
);

    localparam int CMP_W = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;

    logic                   r_seeded;
    logic                   r_last;
    logic                   r_stable;
    logic [COUNT_WIDTH-1:0] r_since;
    logic [COUNT_WIDTH-1:0] r_press;
    logic                   r_long_done;

    logic                   n_stable;
    logic [COUNT_WIDTH-1:0] n_since;
    logic [COUNT_WIDTH-1:0] n_press;
    logic                   n_long_done;

    logic                   eff_last;
    logic                   eff_stable;
    logic                   level_chg;
    logic                   was_pressed;
    logic                   now_pressed;
    t_tap_event             ev;

    always_comb begin
        // first tick seeds both levels from the pin
        eff_last   = r_seeded ? r_last   : i_pin_level;
        eff_stable = r_seeded ? r_stable : i_pin_level;

        if (i_pin_level != eff_last) begin
            n_since = '0;
        end else if (r_since == '1) begin
            n_since = r_since;
        end else begin
            n_since = r_since + 1'b1;
        end

        n_press = (r_press == '1) ? r_press : r_press + 1'b1;

        level_chg   = (n_since > COUNT_WIDTH'(i_cfg.deb_ticks)) &&
                      (i_pin_level != eff_stable);
        was_pressed = (eff_stable != i_cfg.active_low);
        now_pressed = (i_pin_level != i_cfg.active_low);

        n_stable    = level_chg ? i_pin_level : eff_stable;
        n_long_done = r_long_done;
        ev          = TAP_NONE;

        if (level_chg) begin
            if (!was_pressed && now_pressed) begin
                n_press     = '0;
                n_long_done = 1'b0;
            end else if (was_pressed && !now_pressed) begin
                if (!r_long_done) begin
                    ev = TAP_SHORT;
                end
                n_long_done = 1'b0;
            end
        end

        if ((n_stable != i_cfg.active_low) && !n_long_done &&
            (CMP_W'(n_press) >= CMP_W'(i_cfg.long_ticks))) begin
            n_long_done = 1'b1;
            ev          = TAP_LONG;
        end
    end

    assign o_tap_event = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded    <= 1'b0;
            r_last      <= 1'b1;
            r_stable    <= 1'b1;
            r_since     <= '0;
            r_press     <= '0;
            r_long_done <= 1'b0;
        end else if (i_step) begin
            r_seeded    <= 1'b1;
            r_last      <= i_pin_level;
            r_stable    <= n_stable;
            r_since     <= n_since;
            r_press     <= n_press;
            r_long_done <= n_long_done;
        end
    end

endmodule

`default_nettype wire

// File: src/touch_short_long_tap_detector.sv
// ---------------------------------------------------------------------------
// Touch short/long tap detector
// Debounces a sampled touch pin and reports short and long taps.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Payload
//  in        sink       i_in_valid / o_in_ready      i_pin_level
//  out       source     o_out_valid / i_out_ready    o_tap_event
//  cfg       sink       i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One tick is accepted per clock cycle while the skid register is empty;
// every tick yields exactly one request on the out channel. The state
// update is a single pass of compares and saturating increments, and the
// result is held in an output register backed by a one-entry skid
// register, so the input stays ready while one result waits. Reset is
// synchronous, active low; it clears the state and loads register defaults.
// ---------------------------------------------------------------------------
`default_nettype none
`include "touch_short_long_tap_detector_macros.svh"

module touch_short_long_tap_detector
    import tsltd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_pin_level,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [1:0]                 o_tap_event,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;

    logic       r_out_valid;
    t_tap_event r_out_ev;
    logic       r_skid_valid;
    t_tap_event r_skid_ev;

    logic       in_acc;
    logic       out_take;
    t_tap_event step_ev;

    // Configuration registers: write at once, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low <= RST_ACTIVE_LOW;
            r_cfg.long_ticks <= RST_LONG_TICKS;
            r_cfg.deb_ticks  <= RST_DEB_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE_LOW: r_cfg.active_low <= i_cfg_data[0];
                CFG_LONG_TICKS: r_cfg.long_ticks <= i_cfg_data[LONG_W-1:0];
                CFG_DEB_TICKS:  r_cfg.deb_ticks  <= i_cfg_data[DEB_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // Ready depends only on the skid register, never on the sink
    assign o_in_ready = !r_skid_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_take   = r_out_valid && i_out_ready;

    tsltd_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_acc),
        .i_pin_level (i_pin_level),
        .i_cfg       (r_cfg),
        .o_tap_event (step_ev)
    );

    // Output register with skid: advance skid into output when taken; else
    // load a fresh result into a free output, or park it in the skid on a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_ev <= r_skid_ev;
            end
        end else if (in_acc) begin
            if (!r_out_valid || out_take) begin
                r_out_ev <= step_ev;
            end else begin
                r_skid_ev <= step_ev;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tap_event = r_out_ev;

    // Skid holds a result only behind a full output register
    `TSLTD_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // Every accepted tick leaves a result pending in the next cycle
    `TSLTD_ASSERT_NEXT(a_accept_gives_out, i_clk, i_rst_n, in_acc, r_out_valid)
    // A stalled output with a full skid must keep the input closed
    `TSLTD_ASSERT_NEXT(a_skid_blocks, i_clk, i_rst_n, r_skid_valid && !i_out_ready, !o_in_ready)

endmodule

`default_nettype wire
